// ===== sv/qrmp_pkg.sv =====
`timescale 1ns / 1ps

package qrmp_pkg;

    // Field and state widths fixed by the symbol format
    localparam int SIDE_W = 8;
    localparam int RUN_W  = 8;
    localparam int WIN_W  = 10;
    localparam int PEN_W  = 18;
    localparam int STEP_W = 11;
    localparam int DARK_W = 15;

    localparam logic [SIDE_W-1:0] MIN_SIDE = 8'd21;
    localparam logic [PEN_W-1:0]  PEN_MAX  = 18'h3FFFF;
    localparam logic [DARK_W-1:0] DARK_MAX = 15'h7FFF;
    localparam logic [WIN_W:0]    FINDER_A = 11'd93;
    localparam logic [WIN_W:0]    FINDER_B = 11'd1488;

    // Configuration register indexes
    localparam logic CFG_MASK_SELECT = 1'b0;
    localparam logic CFG_SYMBOL_SIDE = 1'b1;

    // One column entry of the state memory
    typedef struct packed {
        logic [RUN_W-1:0] run;
        logic             last;
        logic [WIN_W-1:0] win;
    } col_state_t;

    // Product of two residues mod 3
    function automatic logic [1:0] mul_mod3(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] res;
        res = 2'd0;
        if (a != 2'd0 && b != 2'd0)
        begin
            res = (a == b) ? 2'd1 : 2'd2;
        end
        return res;
    endfunction

    // Standard data-mask condition from row/column phases
    function automatic logic mask_hit(
        input logic [2:0] sel,
        input logic       i0,
        input logic       i1,
        input logic       j0,
        input logic [1:0] im3,
        input logic [1:0] jm3,
        input logic       jd3
    );
        logic       hit;
        logic [1:0] pm3;
        logic [2:0] sm3;
        pm3 = mul_mod3(im3, jm3);
        sm3 = {1'b0, im3} + {1'b0, jm3};
        case (sel)
            3'd0: hit = !(i0 ^ j0);
            3'd1: hit = !i0;
            3'd2: hit = (jm3 == 2'd0);
            3'd3: hit = (sm3 == 3'd0) || (sm3 == 3'd3);
            3'd4: hit = !(i1 ^ jd3);
            3'd5: hit = !(i0 & j0) && (pm3 == 2'd0);
            3'd6: hit = !((i0 & j0) ^ pm3[0]);
            default: hit = !((i0 ^ j0) ^ pm3[0]);
        endcase
        return hit;
    endfunction

    // Run of five or more costs 3+(len-5)
    function automatic logic [RUN_W:0] run_cost(input logic [RUN_W:0] len);
        return (len >= 9'd5) ? len - 9'd2 : 9'd0;
    endfunction

    function automatic logic [5:0] finder_cost(input logic [WIN_W:0] win);
        return (win == FINDER_A || win == FINDER_B) ? 6'd40 : 6'd0;
    endfunction

endpackage

// ===== sv/qrmp_ram.sv =====
`timescale 1ns / 1ps

module qrmp_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 177
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/qrmp_div.sv =====
`timescale 1ns / 1ps

module qrmp_div #(
    parameter int NW = 22,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    logic [DW-1:0]          rem_reg, rem_next;
    logic [NW-1:0]          quo_reg, quo_next;
    logic [DW-1:0]          dsr_reg;
    logic [$clog2(NW+1)-1:0] cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DW:0]            trial;

    // One restoring step per cycle, one quotient bit each
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NW-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = ($clog2(NW+1))'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DW'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 0)
        else $error("divider busy with empty step count");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not start");
`endif

endmodule

// ===== sv/qr_mask_and_penalty_scorer.sv =====
`timescale 1ns / 1ps

// QR data-mask and penalty scorer. Modules enter in raster order; each one
// is masked by the selected pattern (function modules pass unchanged) and
// leaves as one output beat carrying masked_dark. An ordinary module reads
// the per-column state memory on acceptance, then is updated and written
// back as its beat loads, which waits while the output is stalled. The
// last module of a symbol also runs the dark-ratio division, a 22-step
// restoring divider, via S_PREP, S_DIV and S_FIN before the beat with
// penalty_valid and penalty_total. The user must give configuration only
// between symbols, as the block does not enforce it; no column memory clear.
module qr_mask_and_penalty_scorer #(
    parameter int MAX_SIDE = 177
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [qrmp_pkg::SIDE_W-1:0]  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         module_dark,
    input  logic                         is_function,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         masked_dark,
    output logic                         penalty_valid,
    output logic [qrmp_pkg::PEN_W-1:0]   penalty_total
);

    import qrmp_pkg::*;

    localparam int AW    = $clog2(MAX_SIDE);
    localparam int CST_W = $bits(col_state_t);
    localparam int NW    = 22;
    localparam int DW    = 16;

    typedef enum logic [2:0] {S_IDLE, S_CALC, S_PREP, S_DIV, S_FIN} state_t;

    state_t            state_reg;
    logic [2:0]        mask_sel_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [AW-1:0]     col_reg;
    logic [AW-1:0]     row_reg;
    logic [1:0]        im3_reg, jm3_reg;
    logic              jd3_reg;
    logic [RUN_W-1:0]  rrun_reg;
    logic              rlast_reg;
    logic [WIN_W-1:0]  rwin_reg;
    logic [1:0]        lpair_reg;
    logic [DARK_W-1:0] dark_reg;
    logic [PEN_W-1:0]  acc_reg;
    logic              m_reg;
    logic              out_valid_reg, pv_reg;
    logic              md_reg;
    logic [PEN_W-1:0]  total_reg;

    logic              accept, out_free, beat_load;
    logic              hit, m_in;
    logic [SIDE_W-1:0] side_eff;
    logic              last_col, last_row;
    col_state_t        rd, wr;
    logic [RUN_W:0]    rrun_n, cr;
    logic [WIN_W-1:0]  rwin_n;
    logic              above;
    logic [STEP_W-1:0] pen;
    logic [PEN_W:0]    acc_sum;
    logic [PEN_W-1:0]  acc_next;
    logic [DARK_W-1:0] dark_next;
    logic [NW-1:0]     dividend, quotient;
    logic [DW-1:0]     divisor;
    logic              div_start, div_done;
    logic [6:0]        pct, lo, hi, dlo, dhi, ratio;
    logic [14:0]       q5_prod;
    logic [PEN_W:0]    total_sum;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // Load a new output beat on an ordinary module or at the end of a symbol
    assign beat_load = out_free
                       && ((state_reg == S_CALC && !(last_col && last_row))
                           || state_reg == S_FIN);

    // Mask from the row and column phase counters
    assign hit  = mask_hit(mask_sel_reg, row_reg[0], row_reg[1], col_reg[0],
                           im3_reg, jm3_reg, jd3_reg);
    assign m_in = module_dark ^ (hit && !is_function);

    // Clamp the side to the supported range
    always_comb
    begin
        if (side_reg < MIN_SIDE)
        begin
            side_eff = MIN_SIDE;
        end
        else if (side_reg > SIDE_W'(MAX_SIDE))
        begin
            side_eff = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_eff = side_reg;
        end
    end

    assign last_col = ((9)'(col_reg) + 9'd1) >= {1'b0, side_eff};
    assign last_row = ((9)'(row_reg) + 9'd1) >= {1'b0, side_eff};

    qrmp_ram #(
        .WIDTH (CST_W),
        .DEPTH (MAX_SIDE)
    ) u_col_mem (
        .clk   (clk),
        .we    (state_reg == S_CALC && out_free),
        .waddr (col_reg),
        .wdata (wr),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd)
    );

    // Row and column penalty terms for the held module
    always_comb
    begin
        pen    = '0;
        rrun_n = 9'd1;
        rwin_n = {{(WIN_W-1){1'b0}}, m_reg};
        if (col_reg != '0)
        begin
            if (m_reg == rlast_reg)
            begin
                rrun_n = {1'b0, rrun_reg} + 9'd1;
            end
            else
            begin
                pen = pen + STEP_W'(run_cost({1'b0, rrun_reg}));
            end
            if ((9)'(col_reg) >= 9'd10)
            begin
                pen = pen + STEP_W'(finder_cost({rwin_reg, m_reg}));
            end
            rwin_n = {rwin_reg[WIN_W-2:0], m_reg};
        end
        if (last_col)
        begin
            pen = pen + STEP_W'(run_cost(rrun_n));
        end

        above  = rd.last;
        cr     = 9'd1;
        wr.win = {{(WIN_W-1){1'b0}}, m_reg};
        if (row_reg == '0)
        begin
            above = 1'b0;
        end
        else
        begin
            if (col_reg != '0 && lpair_reg[1] == lpair_reg[0]
                && lpair_reg[0] == rd.last && rd.last == m_reg)
            begin
                pen = pen + STEP_W'(3);
            end
            if (m_reg == rd.last)
            begin
                cr = {1'b0, rd.run} + 9'd1;
            end
            else
            begin
                pen = pen + STEP_W'(run_cost({1'b0, rd.run}));
            end
            if ((9)'(row_reg) >= 9'd10)
            begin
                pen = pen + STEP_W'(finder_cost({rd.win, m_reg}));
            end
            wr.win = {rd.win[WIN_W-2:0], m_reg};
        end
        if (last_row)
        begin
            pen = pen + STEP_W'(run_cost(cr));
        end
        wr.run  = cr[RUN_W] ? {RUN_W{1'b1}} : cr[RUN_W-1:0];
        wr.last = m_reg;

        acc_sum  = {1'b0, acc_reg} + (PEN_W+1)'(pen);
        acc_next = acc_sum[PEN_W] ? PEN_MAX : acc_sum[PEN_W-1:0];
    end

    assign dark_next = (dark_reg != DARK_MAX) ? dark_reg + DARK_W'(m_reg) : dark_reg;

    // Dark ratio: dark*100 over side squared
    assign dividend  = (NW'(dark_reg) << 6) + (NW'(dark_reg) << 5) + (NW'(dark_reg) << 2);
    assign divisor   = {{(DW-SIDE_W){1'b0}}, side_eff} * {{(DW-SIDE_W){1'b0}}, side_eff};
    assign div_start = (state_reg == S_PREP);

    qrmp_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Round the percentage down to a 5% step and score the nearer bound
    always_comb
    begin
        pct     = (quotient > NW'(100)) ? 7'd100 : quotient[6:0];
        q5_prod = 15'(pct) * 15'd205;
        lo      = 7'(q5_prod[14:10] * 5);
        hi      = lo + 7'd5;
        dlo     = (lo > 7'd50) ? lo - 7'd50 : 7'd50 - lo;
        dhi     = (hi > 7'd50) ? hi - 7'd50 : 7'd50 - hi;
        ratio   = (dhi <= dlo) ? {dhi[5:0], 1'b0} : {dlo[5:0], 1'b0};
        total_sum = {1'b0, acc_reg} + (PEN_W+1)'(ratio);
    end

    // Sequencer, symbol state and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mask_sel_reg  <= '0;
            side_reg      <= MIN_SIDE;
            col_reg       <= '0;
            row_reg       <= '0;
            im3_reg       <= '0;
            jm3_reg       <= '0;
            jd3_reg       <= 1'b0;
            rrun_reg      <= '0;
            rlast_reg     <= 1'b0;
            rwin_reg      <= '0;
            lpair_reg     <= '0;
            dark_reg      <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            pv_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASK_SELECT: mask_sel_reg <= cfg_data[2:0];
                    CFG_SYMBOL_SIDE: side_reg     <= cfg_data;
                    default: ;
                endcase
            end
            if (beat_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    if (out_free)
                    begin
                        rrun_reg  <= rrun_n[RUN_W-1:0];
                        rwin_reg  <= rwin_n;
                        rlast_reg <= m_reg;
                        lpair_reg <= {above, m_reg};
                        dark_reg  <= dark_next;
                        acc_reg   <= acc_next;
                        if (last_col && last_row)
                        begin
                            state_reg <= S_PREP;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                            pv_reg    <= 1'b0;
                        end
                        if (last_col)
                        begin
                            col_reg <= '0;
                            jm3_reg <= '0;
                            jd3_reg <= 1'b0;
                            if (last_row)
                            begin
                                row_reg <= '0;
                                im3_reg <= '0;
                            end
                            else
                            begin
                                row_reg <= row_reg + 1'b1;
                                im3_reg <= (im3_reg == 2'd2) ? 2'd0 : im3_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            col_reg <= col_reg + 1'b1;
                            jm3_reg <= (jm3_reg == 2'd2) ? 2'd0 : jm3_reg + 2'd1;
                            if (jm3_reg == 2'd2)
                            begin
                                jd3_reg <= !jd3_reg;
                            end
                        end
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        pv_reg    <= 1'b1;
                        acc_reg   <= '0;
                        dark_reg  <= '0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: input capture and output beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg <= m_in;
        end
        if (state_reg == S_CALC && out_free)
        begin
            md_reg    <= m_reg;
            total_reg <= '0;
        end
        if (state_reg == S_FIN && out_free)
        begin
            total_reg <= total_sum[PEN_W] ? PEN_MAX : total_sum[PEN_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign masked_dark   = md_reg;
    assign penalty_valid = pv_reg;
    assign penalty_total = total_reg;

`ifndef SYNTHESIS
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (9)'(col_reg) < 9'(MAX_SIDE) && (9)'(row_reg) < 9'(MAX_SIDE))
        else $error("column or row index beyond memory depth");
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait state");
    a_symbol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> dark_reg == '0 && acc_reg == '0)
        else $error("symbol totals not cleared after last module");
    a_total_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pv_reg) |-> total_reg == '0)
        else $error("penalty total shown on an ordinary module");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import qrmp_pkg::*;

    localparam int COLS      = 177;
    localparam int IDLE_MAX  = 3000;
    localparam int HOLD_LEN  = 400;
    localparam int SETTLE    = 40;

    // Mask, score and keep the expected beats of one symbol stream
    class qr_score_board;
        logic [2:0] mask_sel;
        logic [7:0] side_reg;
        int         col_run [COLS];
        logic       col_last [COLS];
        logic [9:0] col_win [COLS];
        int         row_run;
        logic       row_last;
        logic [9:0] row_win;
        logic [1:0] left_pair;
        int         col_idx;
        int         row_idx;
        int         darks;
        int         pen_acc;
        logic       exp_dark [$];
        logic       exp_pv [$];
        logic [17:0] exp_total [$];
        int         errors;

        function new();
            mask_sel = 3'd0;
            side_reg = 8'd21;
            foreach (col_run[k])
            begin
                col_run[k] = 0;
                col_last[k] = 1'b0;
                col_win[k] = 10'd0;
            end
            row_run = 0;
            row_last = 1'b0;
            row_win = 10'd0;
            left_pair = 2'd0;
            col_idx = 0;
            row_idx = 0;
            darks = 0;
            pen_acc = 0;
            errors = 0;
        endfunction

        function int pending();
            return exp_dark.size();
        endfunction

        function int eff_side();
            int s;
            s = side_reg;
            if (s < 21)
                s = 21;
            if (s > COLS)
                s = COLS;
            return s;
        endfunction

        function bit pattern_hit(int i, int j);
            int p;
            p = i * j;
            case (mask_sel)
                3'd0: return ((i + j) % 2) == 0;
                3'd1: return (i % 2) == 0;
                3'd2: return (j % 3) == 0;
                3'd3: return ((i + j) % 3) == 0;
                3'd4: return ((i / 2 + j / 3) % 2) == 0;
                3'd5: return (p % 2 + p % 3) == 0;
                3'd6: return ((p % 2 + p % 3) % 2) == 0;
                default: return (((i + j) % 2 + p % 3) % 2) == 0;
            endcase
        endfunction

        function int run_pen(int len);
            return (len >= 5) ? len - 2 : 0;
        endfunction

        function int finder_pen(logic [9:0] win, logic bit_in);
            logic [10:0] w;
            w = {win, bit_in};
            return (w == 11'd93 || w == 11'd1488) ? 40 : 0;
        endfunction

        function int sat(int a);
            return (a > 262143) ? 262143 : a;
        endfunction

        function int ratio_pen(int s);
            int pct, lo, hi, dlo, dhi;
            pct = darks * 100 / (s * s);
            if (pct > 100)
                pct = 100;
            lo = pct - pct % 5;
            hi = lo + 5;
            dlo = (lo > 50) ? lo - 50 : 50 - lo;
            dhi = (hi > 50) ? hi - 50 : 50 - hi;
            return 2 * ((dhi <= dlo) ? dhi : dlo);
        endfunction

        // Advance the symbol state by one accepted module
        function void note_input(logic dark, logic fn);
            int   s, r, c, pen, cr;
            logic m, above, cl;
            logic [9:0] cw;
            bit   lc, lr;
            s = eff_side();
            r = row_idx;
            c = col_idx;
            pen = 0;
            m = dark;
            if (!fn && pattern_hit(r, c))
                m = ~m;
            if (darks < 32767)
                darks += m;
            lc = (c + 1 >= s);
            lr = (r + 1 >= s);

            // Row direction
            if (c == 0)
            begin
                row_run = 1;
                row_win = {9'd0, m};
            end
            else
            begin
                if (m == row_last)
                    row_run++;
                else
                begin
                    pen += run_pen(row_run);
                    row_run = 1;
                end
                if (c >= 10)
                    pen += finder_pen(row_win, m);
                row_win = {row_win[8:0], m};
            end
            row_last = m;
            if (lc)
                pen += run_pen(row_run);

            // Column direction and 2x2 blocks
            above = col_last[c];
            cl = above;
            cr = col_run[c];
            cw = col_win[c];
            if (r == 0)
            begin
                cr = 1;
                cw = {9'd0, m};
                above = 1'b0;
            end
            else
            begin
                if (c > 0 && left_pair[1] == left_pair[0] && left_pair[0] == above
                    && above == m)
                    pen += 3;
                if (m == cl)
                    cr++;
                else
                begin
                    pen += run_pen(cr);
                    cr = 1;
                end
                if (r >= 10)
                    pen += finder_pen(cw, m);
                cw = {cw[8:0], m};
            end
            left_pair = {above, m};
            if (lr)
                pen += run_pen(cr);
            col_run[c] = (cr > 255) ? 255 : cr;
            col_last[c] = m;
            col_win[c] = cw;
            pen_acc = sat(pen_acc + pen);

            exp_dark.push_back(m);
            if (lc && lr)
            begin
                exp_pv.push_back(1'b1);
                exp_total.push_back(18'(sat(pen_acc + ratio_pen(s))));
                pen_acc = 0;
                darks = 0;
                col_idx = 0;
                row_idx = 0;
            end
            else
            begin
                exp_pv.push_back(1'b0);
                exp_total.push_back(18'd0);
                if (lc)
                begin
                    col_idx = 0;
                    row_idx = r + 1;
                end
                else
                    col_idx = c + 1;
            end
        endfunction

        function void report(string what, int got, int want);
            errors++;
            $display("mismatch %s: got %0d, expected %0d", what, got, want);
        endfunction

        // Compare one output beat with the oldest expectation
        function void check_result(logic md, logic pv, logic [17:0] pt);
            logic        e_md, e_pv;
            logic [17:0] e_pt;
            if (exp_dark.size() == 0)
            begin
                report("unexpected beat", 1, 0);
                return;
            end
            e_md = exp_dark.pop_front();
            e_pv = exp_pv.pop_front();
            e_pt = exp_total.pop_front();
            if (md !== e_md)
                report("masked_dark", md, e_md);
            if (pv !== e_pv)
                report("penalty_valid", pv, e_pv);
            if (pt !== e_pt)
                report("penalty_total", pt, e_pt);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        module_dark;
    logic        is_function;
    logic        out_valid;
    logic        out_stall;
    logic        masked_dark;
    logic        penalty_valid;
    logic [17:0] penalty_total;

    qr_score_board scores;
    int          accepted;
    int          idle_cycles;
    int          hold_left;
    bit          hold_done;
    int          burst_left;
    int          drv_r;
    int          drv_c;

    qr_mask_and_penalty_scorer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .module_dark   (module_dark),
        .is_function   (is_function),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .masked_dark   (masked_dark),
        .penalty_valid (penalty_valid),
        .penalty_total (penalty_total)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Note accepted modules and check output beats
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            scores.note_input(module_dark, is_function);
            accepted++;
        end
        if (rst_n && out_valid && !out_stall)
            scores.check_result(masked_dark, penalty_valid, penalty_total);
    end

    // Watchdog on cycles with no beat taken on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Output stall pattern, with one long hold-off early in the run
    always @(negedge clk)
    begin
        if (!hold_done && accepted >= 100)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (($urandom / 512) % 4 == 0)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom % 3 == 0);
    end

    task automatic write_reg(logic idx, logic [7:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_MASK_SELECT)
            scores.mask_sel = val[2:0];
        else
            scores.side_reg = val;
    endtask

    // Offer one module and hold it until taken; bursts with random gaps
    task automatic send_module(logic d, logic f);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom % 3 == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        module_dark <= d;
        is_function <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Send a run of modules in raster order with content of the given style
    task automatic send_chunk(int style, int count);
        int   s, r, c;
        logic d, f;
        logic [10:0] finder;
        finder = 11'b00001011101;
        for (int k = 0; k < count; k++)
        begin
            s = scores.eff_side();
            r = drv_r;
            c = drv_c;
            case (style)
                0:
                begin
                    d = 1'b0;
                    f = 1'b1;
                end
                1:
                begin
                    d = 1'b1;
                    f = 1'b1;
                end
                2:
                begin
                    d = finder[10 - ((c + r % 2 * 6) % 11)];
                    f = 1'b1;
                end
                3:
                begin
                    d = $urandom % 2;
                    f = ($urandom % 4 == 0);
                end
                default:
                begin
                    d = ((r / 3 + c / 4) % 2) ^ ($urandom % 16 == 0);
                    f = ($urandom % 8 == 0);
                end
            endcase
            send_module(d, f);
            if (c + 1 >= s)
            begin
                drv_c = 0;
                drv_r = (r + 1 >= s) ? 0 : r + 1;
            end
            else
                drv_c = c + 1;
        end
    endtask

    int mask_plan [10] = '{0, 1, 2, 3, 4, 5, 6, 7, 7, 0};
    int side_plan [10] = '{0, 21, 21, 8, 21, 21, 21, 21, 255, 255};
    int style_plan [10] = '{0, 1, 2, 3, 4, 3, 4, 3, 4, 3};
    int count_plan [10] = '{50, 50, 60, 60, 60, 60, 50, 51, 120, 90};

    initial
    begin
        scores = new();
        accepted = 0;
        idle_cycles = 0;
        hold_left = 0;
        hold_done = 1'b0;
        burst_left = 0;
        drv_r = 0;
        drv_c = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MASK_SELECT;
        cfg_data = 8'd0;
        in_valid = 1'b0;
        module_dark = 1'b0;
        is_function = 1'b0;
        out_stall = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (mask_plan[p])
        begin
            // Reconfigure only once the previous run has drained
            write_reg(CFG_MASK_SELECT, 8'(mask_plan[p]));
            write_reg(CFG_SYMBOL_SIDE, 8'(side_plan[p]));
            @(negedge clk);
            cfg_we <= 1'b0;
            send_chunk(style_plan[p], count_plan[p]);
            @(negedge clk);
            in_valid <= 1'b0;
            burst_left = 0;
            while (scores.pending() > 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end

        if (scores.errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
